/* rtl/cfl_pkg.sv */
package cfl_pkg;

    localparam int RX_MAX      = 32;
    localparam int TX_DATA_MAX = 32;
    localparam int PEND_MAX    = TX_DATA_MAX + 2;
    localparam int RES_MAX     = 39;
    localparam int RX_AW       = $clog2(RX_MAX);
    localparam int PEND_AW     = $clog2(PEND_MAX);
    localparam int CNT_W       = 6;

    localparam logic [7:0] B_PRE  = 8'hFE;
    localparam logic [7:0] B_END  = 8'hFD;
    localparam logic [7:0] B_NOSC = 8'hFF;
    localparam logic [7:0] B_ACK  = 8'hFB;
    localparam logic [7:0] B_NACK = 8'hFA;

    // input word types
    localparam logic [1:0] T_RX    = 2'd0;
    localparam logic [1:0] T_TICK  = 2'd1;
    localparam logic [1:0] T_START = 2'd2;
    localparam logic [1:0] T_DATA  = 2'd3;

    // result kinds
    localparam logic [1:0] K_TX     = 2'd0;
    localparam logic [1:0] K_PAY    = 2'd1;
    localparam logic [1:0] K_EMPTY  = 2'd2;
    localparam logic [1:0] K_STATUS = 2'd3;

    localparam logic [1:0] C_ACK  = 2'd0;
    localparam logic [1:0] C_NACK = 2'd1;
    localparam logic [1:0] C_DATA = 2'd2;
    localparam logic [1:0] C_UNK  = 2'd3;

    localparam logic [1:0] S_OK   = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_GAVE = 2'd2;

    localparam logic [1:0] R_RADIO = 2'd0;
    localparam logic [1:0] R_CTRL  = 2'd1;
    localparam logic [1:0] R_TMO   = 2'd2;
    localparam logic [1:0] R_TRIES = 2'd3;

    // back-end job codes
    localparam logic [2:0] J_SINGLE = 3'd0; // up to 7 fixed results
    localparam logic [2:0] J_RESEND = 3'd1; // head, pending store, FD
    localparam logic [2:0] J_PAY    = 3'd2; // payload from rx store

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [15:0] command;
        logic [5:0]  req_data_count;
        logic        wait_response;
        logic [7:0]  req_data_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] response_class;
        logic [1:0] req_status;
    } out_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_val;
        logic [1:0] cls;
        logic [1:0] st;
    } res_t;

    // job from front to back
    typedef struct packed {
        logic [2:0]       job;
        logic [2:0]       n;      // singles used
        res_t [6:0]       r;
        logic [CNT_W-1:0] len;    // resend / payload byte count; trailing FD count for singles
    } job_t;

endpackage

/* rtl/civ_frame_link_with_retry.sv */
// channel  | dir | handshake            | word
// in       | in  | in_valid / in_ready  | in_word_t  (rx byte, tick, start, data)
// out      | out | out_valid / out_ready| out_word_t (tx, payload, empty, status)
// cfg      | in  | cfg_we               | cfg_index, cfg_data
// The front end takes one word a cycle when its job register is free; it
// holds in the cycle after a waiting start with a subcommand (slot 1 write) and
// while a resend or payload job is queued or running (stores are being read).
// Each result passes through two steps in the back end (memory fetch, then
// emit), and a stall on out holds the emit step.
// Reset is asynchronous; all control state clears at once, no clearing pass.
// A stall on out holds the back end, then the job register, then in_ready.
module civ_frame_link_with_retry import cfl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word
);

    logic job_valid, job_ready, mem_busy;
    job_t job;
    logic [7:0] radio_q, ctrl_q;
    logic rx_we, pd_we;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [PEND_AW-1:0] pd_waddr, pd_raddr;
    logic [7:0] rx_wdata, pd_wdata, rx_rdata, pd_rdata;
    logic [7:0] b0_reg, b1_reg, b2_reg;

    // header bytes of the frame kept in flops for the end-of-frame check
    always_ff @(posedge clk)
    begin
        if (rx_we && rx_waddr == RX_AW'(0)) b0_reg <= rx_wdata;
        if (rx_we && rx_waddr == RX_AW'(1)) b1_reg <= rx_wdata;
        if (rx_we && rx_waddr == RX_AW'(2)) b2_reg <= rx_wdata;
    end

    cfl_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .in_word,
        .job_valid, .job_ready, .job, .mem_busy, .radio_q, .ctrl_q,
        .rx_we, .rx_waddr, .rx_wdata, .pd_we, .pd_waddr, .pd_wdata,
        .rx_b0(b0_reg), .rx_b1(b1_reg), .rx_b2(b2_reg)
    );

    cfl_ram #(.WIDTH(8), .DEPTH(RX_MAX)) u_rx_ram (
        .clk, .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
        .raddr(rx_raddr), .rdata(rx_rdata)
    );

    cfl_ram #(.WIDTH(8), .DEPTH(PEND_MAX)) u_pd_ram (
        .clk, .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
        .raddr(pd_raddr), .rdata(pd_rdata)
    );

    cfl_back u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job, .mem_busy, .radio_q, .ctrl_q,
        .rx_raddr, .rx_rdata, .pd_raddr, .pd_rdata,
        .out_valid, .out_ready, .out_word
    );

endmodule

/* rtl/cfl_ram.sv */
module cfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/cfl_front.sv */
module cfl_front import cfl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_word,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job,
    input  logic        mem_busy,
    output logic [7:0]  radio_q,
    output logic [7:0]  ctrl_q,
    output logic              rx_we,
    output logic [RX_AW-1:0]  rx_waddr,
    output logic [7:0]        rx_wdata,
    output logic              pd_we,
    output logic [PEND_AW-1:0] pd_waddr,
    output logic [7:0]        pd_wdata,
    input  logic [7:0]        rx_b0,
    input  logic [7:0]        rx_b1,
    input  logic [7:0]        rx_b2
);

    logic [7:0]  radio_reg, ctrl_reg;
    logic [15:0] tmo_reg;
    logic [2:0]  tries_reg;
    logic [1:0]  ph_reg;
    logic [CNT_W-1:0] rxc_reg, pc_reg, left_reg;
    logic [2:0]  sends_reg;
    logic [15:0] wc_reg;
    logic        want_reg, kept_reg;

    logic [1:0]  ph_next;
    logic [CNT_W-1:0] rxc_next, pc_next, left_next, cnt;
    logic [2:0]  sends_next;
    logic [15:0] wc_next, wc_inc;
    logic        want_next, kept_next;
    job_t        j;
    logic        emit;
    logic [7:0]  cn, sc;

    logic              pd_we_c;
    logic [PEND_AW-1:0] pd_waddr_c;
    logic [7:0]        pd_wdata_c;
    logic              sc_pend_reg;
    logic [7:0]        sc_val_reg;
    logic              sc_we;

    assign radio_q  = radio_reg;
    assign ctrl_q   = ctrl_reg;
    // input waits for the slot 1 write and while a job reads the stores
    assign in_ready = (!job_valid || job_ready) && !sc_pend_reg && !mem_busy
                      && !(job_valid && job.job != J_SINGLE);
    assign cn = in_word.command[15:8];
    assign sc = in_word.command[7:0];

    function automatic res_t mk(logic [1:0] k, logic [7:0] b, logic [1:0] c, logic [1:0] s);
        res_t r;
        r.kind = k; r.byte_val = b; r.cls = c; r.st = s;
        return r;
    endfunction

    // classify one input word
    always_comb
    begin
        ph_next = ph_reg; rxc_next = rxc_reg; pc_next = pc_reg; left_next = left_reg;
        sends_next = sends_reg; wc_next = wc_reg; want_next = want_reg; kept_next = kept_reg;
        j = '0; j.job = J_SINGLE; emit = 1'b0;
        rx_we = 1'b0; rx_waddr = rxc_reg[RX_AW-1:0]; rx_wdata = in_word.rx_byte;
        pd_we_c = 1'b0; pd_waddr_c = pc_reg[PEND_AW-1:0]; pd_wdata_c = in_word.req_data_byte;
        wc_inc = (wc_reg == 16'hFFFF) ? wc_reg : wc_reg + 16'd1;
        cnt = (in_word.req_data_count > CNT_W'(TX_DATA_MAX)) ? CNT_W'(TX_DATA_MAX)
                                                             : in_word.req_data_count;
        case (in_word.req_type)
            T_RX:
            begin
                case (ph_reg)
                    2'd0: if (in_word.rx_byte == B_PRE) ph_next = 2'd1;
                    2'd1:
                        if (in_word.rx_byte == B_PRE)
                        begin
                            ph_next = 2'd2; rxc_next = '0;
                        end
                    default:
                    begin
                        if (in_word.rx_byte == B_END)
                        begin
                            ph_next = 2'd0;
                            if (rxc_reg >= CNT_W'(2)
                                && !(rx_b0 == radio_reg && rx_b1 == ctrl_reg)
                                && rx_b0 == ctrl_reg && rx_b1 == radio_reg)
                            begin
                                emit = 1'b1;
                                if (rxc_reg == CNT_W'(2))
                                begin
                                    j.n = 3'd1; j.r[0] = mk(K_EMPTY, 8'd0, 2'd0, S_OK);
                                end
                                else if (rxc_reg == CNT_W'(3))
                                begin
                                    j.n = 3'd1;
                                    if (rx_b2 == B_ACK || rx_b2 == B_NACK)
                                    begin
                                        pc_next = '0; sends_next = '0; wc_next = '0;
                                        kept_next = 1'b0;
                                    end
                                    j.r[0] = mk(K_PAY, rx_b2,
                                        (rx_b2 == B_ACK) ? C_ACK :
                                        (rx_b2 == B_NACK) ? C_NACK : C_UNK, S_OK);
                                end
                                else
                                begin
                                    pc_next = '0; sends_next = '0; wc_next = '0;
                                    kept_next = 1'b0;
                                    j.job = J_PAY; j.len = rxc_reg - CNT_W'(2);
                                end
                            end
                        end
                        else if (rxc_reg >= CNT_W'(RX_MAX))
                        begin
                            ph_next = 2'd0;
                        end
                        else
                        begin
                            rx_we = in_valid && in_ready;
                            rxc_next = rxc_reg + CNT_W'(1);
                        end
                    end
                endcase
            end
            T_TICK:
            begin
                if (pc_reg != '0 && !want_reg)
                begin
                    wc_next = wc_inc;
                    if (wc_inc > tmo_reg)
                    begin
                        emit = 1'b1;
                        if (sends_reg < tries_reg)
                        begin
                            j.job = J_RESEND; j.len = pc_reg;
                            sends_next = sends_reg + 3'd1; wc_next = '0;
                        end
                        else
                        begin
                            pc_next = '0; sends_next = '0; wc_next = '0; kept_next = 1'b0;
                            j.n = 3'd1; j.r[0] = mk(K_STATUS, 8'd0, 2'd0, S_GAVE);
                        end
                    end
                end
            end
            T_START:
            begin
                emit = 1'b1;
                if (pc_reg != '0 || want_reg)
                begin
                    j.n = 3'd1; j.r[0] = mk(K_STATUS, 8'd0, 2'd0, S_BUSY);
                end
                else
                begin
                    j.r[0] = mk(K_STATUS, 8'd0, 2'd0, S_OK);
                    j.r[1] = mk(K_TX, B_PRE, 2'd0, S_OK);
                    j.r[2] = mk(K_TX, B_PRE, 2'd0, S_OK);
                    j.r[3] = mk(K_TX, radio_reg, 2'd0, S_OK);
                    j.r[4] = mk(K_TX, ctrl_reg, 2'd0, S_OK);
                    j.r[5] = mk(K_TX, cn, 2'd0, S_OK);
                    j.n = 3'd6;
                    if (sc != B_NOSC)
                    begin
                        j.r[6] = mk(K_TX, sc, 2'd0, S_OK);
                        j.n = 3'd7;
                    end
                    if (cnt == '0)
                    begin
                        // FD follows the singles in the back end
                        j.len = CNT_W'(1);
                    end
                    kept_next = in_word.wait_response;
                    if (in_word.wait_response)
                    begin
                        // pending store: cn at 0 now, sc at 1 on the next cycle
                        pd_we_c = in_valid && in_ready; pd_waddr_c = '0; pd_wdata_c = cn;
                        pc_next = (sc != B_NOSC) ? CNT_W'(2) : CNT_W'(1);
                        sends_next = 3'd1; wc_next = '0;
                    end
                    left_next = cnt; want_next = (cnt != '0);
                end
            end
            default:
            begin
                if (want_reg)
                begin
                    emit = 1'b1;
                    j.n = 3'd1; j.r[0] = mk(K_TX, in_word.req_data_byte, 2'd0, S_OK);
                    if (kept_reg && pc_reg < CNT_W'(PEND_MAX))
                    begin
                        pd_we_c = in_valid && in_ready; pc_next = pc_reg + CNT_W'(1);
                    end
                    left_next = (left_reg != '0) ? left_reg - CNT_W'(1) : left_reg;
                    if (left_next == '0)
                    begin
                        want_next = 1'b0; j.len = CNT_W'(1);
                    end
                end
            end
        endcase
    end

    // subcommand goes into pending slot 1 in the cycle after the start
    assign sc_we = in_valid && in_ready && in_word.req_type == T_START && pc_reg == '0
                   && !want_reg && in_word.wait_response && sc != B_NOSC;
    assign pd_we    = pd_we_c || sc_pend_reg;
    assign pd_waddr = sc_pend_reg ? PEND_AW'(1) : pd_waddr_c;
    assign pd_wdata = sc_pend_reg ? sc_val_reg : pd_wdata_c;

    // registered job output and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radio_reg <= 8'd0; ctrl_reg <= 8'd224; tmo_reg <= 16'd1000; tries_reg <= 3'd3;
            ph_reg <= 2'd0; rxc_reg <= '0; pc_reg <= '0; left_reg <= '0;
            sends_reg <= '0; wc_reg <= '0; want_reg <= 1'b0; kept_reg <= 1'b0;
            job_valid <= 1'b0; sc_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    R_RADIO: radio_reg <= cfg_data[7:0];
                    R_CTRL:  ctrl_reg  <= cfg_data[7:0];
                    R_TMO:   tmo_reg   <= cfg_data;
                    default: tries_reg <= cfg_data[2:0];
                endcase
            end
            sc_pend_reg <= sc_we;
            if (job_ready) job_valid <= 1'b0;
            if (in_valid && in_ready)
            begin
                ph_reg <= ph_next; rxc_reg <= rxc_next; pc_reg <= pc_next;
                left_reg <= left_next; sends_reg <= sends_next; wc_reg <= wc_next;
                want_reg <= want_next; kept_reg <= kept_next;
                job_valid <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_we) sc_val_reg <= sc;
        if (in_valid && in_ready && emit) job <= j;
    end

    assert property (@(posedge clk) disable iff (!rst_n) want_reg |-> left_reg != '0)
        else $error("open request with no bytes left");
    assert property (@(posedge clk) disable iff (!rst_n) pc_reg <= CNT_W'(PEND_MAX))
        else $error("pending count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) rxc_reg <= CNT_W'(RX_MAX))
        else $error("rx count overflow");

endmodule

/* rtl/cfl_back.sv */
module cfl_back import cfl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        mem_busy,
    input  logic [7:0]  radio_q,
    input  logic [7:0]  ctrl_q,
    output logic [RX_AW-1:0]   rx_raddr,
    input  logic [7:0]         rx_rdata,
    output logic [PEND_AW-1:0] pd_raddr,
    input  logic [7:0]         pd_rdata,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word
);

    typedef enum logic [1:0] { ST_IDLE, ST_RUN } st_t;

    st_t        st_reg;
    job_t       jb_reg;
    logic [CNT_W:0] idx_reg;   // result index within the job
    logic [CNT_W:0] tot;
    logic [CNT_W:0] sent_reg;  // results emitted (cap at RES_MAX)
    res_t       r;
    logic       step, fetch_reg;
    logic [CNT_W:0] mem_idx;

    // total results of the job
    always_comb
    begin
        case (jb_reg.job)
            J_RESEND: tot = (CNT_W+1)'(5) + (CNT_W+1)'(jb_reg.len);
            J_PAY:    tot = (CNT_W+1)'(jb_reg.len);
            default:  tot = (CNT_W+1)'(jb_reg.n) + (CNT_W+1)'(jb_reg.len);
        endcase
    end

    // index of the memory read for the current result
    assign mem_idx = (jb_reg.job == J_RESEND) ? idx_reg - (CNT_W+1)'(4) : idx_reg;
    assign rx_raddr = RX_AW'(mem_idx + (CNT_W+1)'(2));
    assign pd_raddr = PEND_AW'(mem_idx);

    // stores must not change while a job reads them
    assign mem_busy = st_reg == ST_RUN && jb_reg.job != J_SINGLE;

    always_comb
    begin
        r = '0;
        case (jb_reg.job)
            J_RESEND:
            begin
                r.kind = K_TX;
                if (idx_reg < (CNT_W+1)'(2)) r.byte_val = B_PRE;
                else if (idx_reg == (CNT_W+1)'(2)) r.byte_val = radio_q;
                else if (idx_reg == (CNT_W+1)'(3)) r.byte_val = ctrl_q;
                else if (idx_reg == tot - (CNT_W+1)'(1)) r.byte_val = B_END;
                else r.byte_val = pd_rdata;
            end
            J_PAY:
            begin
                r.kind = K_PAY; r.cls = C_DATA; r.byte_val = rx_rdata;
            end
            default:
            begin
                if (idx_reg < (CNT_W+1)'(jb_reg.n)) r = jb_reg.r[idx_reg[2:0]];
                else
                begin
                    r.kind = K_TX; r.byte_val = B_END;
                end
            end
        endcase
    end

    // memory reads need a fetch step before each emit
    assign step = st_reg == ST_RUN && fetch_reg && (!out_valid || out_ready);
    assign job_ready = st_reg == ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; idx_reg <= '0; sent_reg <= '0;
            out_valid <= 1'b0; fetch_reg <= 1'b0;
        end
        else
        begin
            if (out_ready) out_valid <= 1'b0;
            case (st_reg)
                ST_IDLE:
                    if (job_valid)
                    begin
                        st_reg <= ST_RUN; idx_reg <= '0; sent_reg <= '0; fetch_reg <= 1'b0;
                    end
                ST_RUN:
                begin
                    if (!fetch_reg) fetch_reg <= 1'b1;
                    else if (step)
                    begin
                        out_valid <= 1'b1;
                        sent_reg <= sent_reg + (CNT_W+1)'(1);
                        idx_reg <= idx_reg + (CNT_W+1)'(1);
                        fetch_reg <= 1'b0;
                        if (idx_reg + (CNT_W+1)'(1) == tot
                            || sent_reg + (CNT_W+1)'(1) == (CNT_W+1)'(RES_MAX))
                        begin
                            st_reg <= ST_IDLE;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && job_valid) jb_reg <= job;
        if (step)
        begin
            out_word.out_kind       <= r.kind;
            out_word.out_byte       <= r.byte_val;
            out_word.response_class <= r.cls;
            out_word.req_status     <= r.st;
            out_word.out_last <= (idx_reg + (CNT_W+1)'(1) == tot)
                || (sent_reg + (CNT_W+1)'(1) == (CNT_W+1)'(RES_MAX));
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) step |-> idx_reg < tot)
        else $error("emit beyond job end");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n) sent_reg <= (CNT_W+1)'(RES_MAX))
        else $error("result limit exceeded");

endmodule
